@@ rtl/core/stod_pkg.sv @@
// ---------------------------------------------------------------------------
// Time-of-day clock package
// Mode and status codes, key codes, time limits and the clock state record
// shared by the time-of-day clock modules.
// ---------------------------------------------------------------------------
package stod_pkg;

   // Operating mode of the clock.
   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_ADJUST  = 2'd1,
      MODE_RUNNING = 2'd2
   } mode_type;

   // Status reported with every result.
   typedef enum logic [2:0] {
      EV_NONE            = 3'd0,
      EV_INVALID         = 3'd1,
      EV_ALREADY_STOPPED = 3'd2,
      EV_RESET           = 3'd3,
      EV_ADJUST_DONE     = 3'd4
   } status_type;

   // ASCII key codes.
   localparam logic [7:0] KEY_ADJUST  = 8'h41; // 'A'
   localparam logic [7:0] KEY_RESET   = 8'h52; // 'R'
   localparam logic [7:0] KEY_GO      = 8'h47; // 'G'
   localparam logic [7:0] KEY_PAUSE   = 8'h50; // 'P'
   localparam logic [7:0] KEY_HOUR    = 8'h48; // 'H'
   localparam logic [7:0] KEY_MINUTE  = 8'h4D; // 'M'
   localparam logic [7:0] KEY_SECOND  = 8'h53; // 'S'
   localparam logic [7:0] KEY_DONE    = 8'h44; // 'D'
   localparam logic [7:0] KEY_IGNORE  = 8'h23; // '#'

   // Field limits and the prescaler reset value.
   localparam logic [5:0]  SEC_MAX        = 6'd59;
   localparam logic [5:0]  MIN_MAX        = 6'd59;
   localparam logic [4:0]  HOUR_MAX       = 5'd23;
   localparam logic [15:0] PRESCALE_RESET = 16'd3906;

   // Request kinds.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   // Complete clock state.
   typedef struct packed {
      mode_type    mode;
      logic [15:0] ticks;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } clock_state_type;

endpackage

@@ rtl/core/settable_time_of_day_clock.sv @@
// ---------------------------------------------------------------------------
// Settable time-of-day clock
// Hours, minutes and seconds clock with a prescaled tick input and a
// key-driven stopped / adjusting / running mode machine.
// ---------------------------------------------------------------------------
// Every request transfer (a timer tick or a key press) produces exactly one
// response transfer with the time, the mode and a status code after that
// request. The clock state is updated in the same cycle as the request is
// taken and the response appears in the next cycle from the output register;
// a new request is taken in every cycle unless the response register is
// full and stalled. The prescale limit is written through the csr port,
// which is always ready; write it only while no request is in flight. One
// second takes prescale limit plus one running ticks.
module settable_time_of_day_clock
   import stod_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_key_code,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_hours,
   output logic [5:0]  rsp_minutes,
   output logic [5:0]  rsp_seconds,
   output logic [1:0]  rsp_clock_mode,
   output logic [2:0]  rsp_event_status,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic            req_accept;
   logic [15:0]     limit_ff;
   clock_state_type state_ff;
   clock_state_type state_in;
   status_type      status;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [4:0]      rsp_hours_ff;
   logic [5:0]      rsp_minutes_ff;
   logic [5:0]      rsp_seconds_ff;
   mode_type        rsp_mode_ff;
   status_type      rsp_status_ff;

   // The request side waits only while a response is held by a stall.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   // Prescale limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= PRESCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Next state and status for the incoming request.
   stod_step u_step (
      .cur_state      (state_ff),
      .item_is_key    (req_type),
      .item_key       (req_key_code),
      .prescale_limit (limit_ff),
      .next_state     (state_in),
      .status         (status)
   );

   // Clock state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_STOPPED, ticks: '0, hours: '0,
                       minutes: '0, seconds: '0};
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Response valid: loaded on a request transfer, held while stalled.
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: the visible time fields, the mode and the status.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_hours_ff   <= state_in.hours;
         rsp_minutes_ff <= state_in.minutes;
         rsp_seconds_ff <= state_in.seconds;
         rsp_mode_ff    <= state_in.mode;
         rsp_status_ff  <= status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hours        = rsp_hours_ff;
   assign rsp_minutes      = rsp_minutes_ff;
   assign rsp_seconds      = rsp_seconds_ff;
   assign rsp_clock_mode   = rsp_mode_ff;
   assign rsp_event_status = rsp_status_ff;

endmodule

@@ rtl/core/stod_step.sv @@
// ---------------------------------------------------------------------------
// Time-of-day clock step logic
// Combinational next state and status for one tick or key transfer.
// ---------------------------------------------------------------------------
module stod_step
   import stod_pkg::*;
(
   input  clock_state_type cur_state,
   input  logic            item_is_key,
   input  logic [7:0]      item_key,
   input  logic [15:0]     prescale_limit,
   output clock_state_type next_state,
   output status_type      status
);

   mode_type next_mode;

   // Next mode of the key-driven mode machine.
   always_comb begin
      next_mode = cur_state.mode;
      if (item_is_key == REQ_KEY) begin
         case (cur_state.mode)
            MODE_ADJUST: begin
               if (item_key == KEY_DONE) begin
                  next_mode = MODE_RUNNING;
               end
            end
            MODE_RUNNING: begin
               if (item_key == KEY_PAUSE) begin
                  next_mode = MODE_STOPPED;
               end
            end
            default: begin
               // Stopped, and the unused code, which behaves as stopped.
               if (item_key == KEY_ADJUST) begin
                  next_mode = MODE_ADJUST;
               end else if (item_key == KEY_GO) begin
                  next_mode = MODE_RUNNING;
               end else if (item_key != KEY_IGNORE) begin
                  next_mode = MODE_STOPPED;
               end
            end
         endcase
      end
   end

   // Time fields, prescaler and status.
   always_comb begin
      next_state.mode    = next_mode;
      next_state.ticks   = cur_state.ticks;
      next_state.hours   = cur_state.hours;
      next_state.minutes = cur_state.minutes;
      next_state.seconds = cur_state.seconds;
      status             = EV_NONE;
      if (item_is_key == REQ_TICK) begin
         // Ticks only count while running; reaching the limit advances a second.
         if (cur_state.mode == MODE_RUNNING) begin
            if (cur_state.ticks >= prescale_limit) begin
               next_state.ticks = '0;
               if (cur_state.seconds < SEC_MAX) begin
                  next_state.seconds = cur_state.seconds + 6'd1;
               end else begin
                  next_state.seconds = '0;
                  if (cur_state.minutes < MIN_MAX) begin
                     next_state.minutes = cur_state.minutes + 6'd1;
                  end else begin
                     next_state.minutes = '0;
                     next_state.hours   = (cur_state.hours >= HOUR_MAX) ?
                                          5'd0 : cur_state.hours + 5'd1;
                  end
               end
            end else begin
               next_state.ticks = cur_state.ticks + 16'd1;
            end
         end
      end else begin
         case (cur_state.mode)
            MODE_ADJUST: begin
               // Each field wraps on its own without carrying.
               if (item_key == KEY_HOUR) begin
                  next_state.hours = (cur_state.hours >= HOUR_MAX) ?
                                     5'd0 : cur_state.hours + 5'd1;
               end else if (item_key == KEY_MINUTE) begin
                  next_state.minutes = (cur_state.minutes >= MIN_MAX) ?
                                       6'd0 : cur_state.minutes + 6'd1;
               end else if (item_key == KEY_SECOND) begin
                  next_state.seconds = (cur_state.seconds >= SEC_MAX) ?
                                       6'd0 : cur_state.seconds + 6'd1;
               end else if (item_key == KEY_DONE) begin
                  status = EV_ADJUST_DONE;
               end
            end
            MODE_RUNNING: begin
               status = EV_NONE;
            end
            default: begin
               if (item_key == KEY_RESET) begin
                  next_state.hours   = '0;
                  next_state.minutes = '0;
                  next_state.seconds = '0;
                  status             = EV_RESET;
               end else if (item_key == KEY_PAUSE) begin
                  status = EV_ALREADY_STOPPED;
               end else if (item_key != KEY_ADJUST && item_key != KEY_GO &&
                            item_key != KEY_IGNORE) begin
                  status = EV_INVALID;
               end
            end
         endcase
      end
   end

endmodule

@@ sim/stod_reading_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Time-of-day clock reading checker
// Watches the request, response and csr channels of the time-of-day clock.
// Every accepted request updates a private copy of the clock state and
// queues the reading that the block should return. Every response transfer
// is compared field by field against the oldest queued reading.
// ---------------------------------------------------------------------------
module stod_reading_checker
   import stod_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_key_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_hours,
   input  logic [5:0]  rsp_minutes,
   input  logic [5:0]  rsp_seconds,
   input  logic [1:0]  rsp_clock_mode,
   input  logic [2:0]  rsp_event_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          readings_outstanding
);

   // One reading of the clock as the response channel carries it.
   typedef struct {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      mode_type   mode;
      status_type status;
   } clock_reading_type;

   // Private copy of the clock state and the prescale register.
   logic [15:0] prescale_limit = PRESCALE_RESET;
   mode_type    mode           = MODE_STOPPED;
   logic [15:0] ticks          = '0;
   logic [4:0]  hours          = '0;
   logic [5:0]  minutes        = '0;
   logic [5:0]  seconds        = '0;

   clock_reading_type expected_readings [$];

   initial begin
      mismatch_count       = 0;
      readings_outstanding = 0;
   end

   // Apply one tick or key press to the clock state and return the new reading.
   function automatic clock_reading_type apply_item(input logic kind, input logic [7:0] key);
      clock_reading_type reading;
      status_type        status;
      status = EV_NONE;
      if (kind == REQ_TICK) begin
         // The prescaler only counts while running; reaching or passing the
         // limit restarts it and advances the time by one second.
         if (mode == MODE_RUNNING) begin
            if (ticks >= prescale_limit) begin
               ticks = '0;
               if (seconds < SEC_MAX) begin
                  seconds = seconds + 6'd1;
               end else begin
                  seconds = '0;
                  if (minutes < MIN_MAX) begin
                     minutes = minutes + 6'd1;
                  end else begin
                     minutes = '0;
                     hours   = (hours >= HOUR_MAX) ? 5'd0 : hours + 5'd1;
                  end
               end
            end else begin
               ticks = ticks + 16'd1;
            end
         end
      end else begin
         case (mode)
            // Adjusting: each field wraps on its own, without a carry.
            MODE_ADJUST: begin
               case (key)
                  KEY_HOUR:   hours   = (hours >= HOUR_MAX) ? 5'd0 : hours + 5'd1;
                  KEY_MINUTE: minutes = (minutes >= MIN_MAX) ? 6'd0 : minutes + 6'd1;
                  KEY_SECOND: seconds = (seconds >= SEC_MAX) ? 6'd0 : seconds + 6'd1;
                  KEY_DONE: begin
                     mode   = MODE_RUNNING;
                     status = EV_ADJUST_DONE;
                  end
                  default: ;
               endcase
            end
            MODE_RUNNING: begin
               if (key == KEY_PAUSE) mode = MODE_STOPPED;
            end
            // Stopped, and any mode code the machine should never hold.
            default: begin
               case (key)
                  KEY_ADJUST: mode = MODE_ADJUST;
                  KEY_RESET: begin
                     hours   = '0;
                     minutes = '0;
                     seconds = '0;
                     mode    = MODE_STOPPED;
                     status  = EV_RESET;
                  end
                  KEY_GO: mode = MODE_RUNNING;
                  KEY_PAUSE: begin
                     mode   = MODE_STOPPED;
                     status = EV_ALREADY_STOPPED;
                  end
                  KEY_IGNORE: ;
                  default: begin
                     mode   = MODE_STOPPED;
                     status = EV_INVALID;
                  end
               endcase
            end
         endcase
      end
      reading.hours   = hours;
      reading.minutes = minutes;
      reading.seconds = seconds;
      reading.mode    = mode;
      reading.status  = status;
      return reading;
   endfunction

   // Report one field that differs from its expected value.
   function automatic int field_mismatch(input string name, input logic [7:0] expected,
                                         input logic [7:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         return 1;
      end
      return 0;
   endfunction

   // Track transfers on all channels. New expectations are queued before the
   // response check so that the oldest reading is always at the front.
   always @(posedge clock) begin
      clock_reading_type oldest;
      int                errors;
      errors = 0;
      if (reset) begin
         prescale_limit = PRESCALE_RESET;
         mode           = MODE_STOPPED;
         ticks          = '0;
         hours          = '0;
         minutes        = '0;
         seconds        = '0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) prescale_limit = csr_data;
         if (req_valid && !req_stall) begin
            expected_readings.push_back(apply_item(req_type, req_key_code));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("response transfer with no reading expected");
               errors++;
            end else begin
               oldest = expected_readings.pop_front();
               errors += field_mismatch("hours", 8'(oldest.hours), 8'(rsp_hours));
               errors += field_mismatch("minutes", 8'(oldest.minutes), 8'(rsp_minutes));
               errors += field_mismatch("seconds", 8'(oldest.seconds), 8'(rsp_seconds));
               errors += field_mismatch("clock_mode", 8'(oldest.mode), 8'(rsp_clock_mode));
               errors += field_mismatch("event_status", 8'(oldest.status),
                                        8'(rsp_event_status));
            end
         end
      end
      mismatch_count       <= mismatch_count + errors;
      readings_outstanding <= expected_readings.size();
   end

endmodule

@@ sim/tb_settable_time_of_day_clock.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Time-of-day clock testbench
// Drives ticks and key presses into the time-of-day clock with random gaps
// and response stalls, over several prescale limits. A short directed part
// walks every mode and key; random sequences then set the time near
// midnight, adjust fields and run bursts of ticks. The checker predicts and
// compares every reading; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_settable_time_of_day_clock;
   import stod_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 210;

   // Keys that the clock reacts to, plus the ignored key.
   localparam logic [7:0] KNOWN_KEYS [9] = '{KEY_ADJUST, KEY_RESET, KEY_GO, KEY_PAUSE,
                                            KEY_HOUR, KEY_MINUTE, KEY_SECOND, KEY_DONE,
                                            KEY_IGNORE};

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic        req_type     = REQ_TICK;
   logic [7:0]  req_key_code = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [4:0]  rsp_hours;
   logic [5:0]  rsp_minutes;
   logic [5:0]  rsp_seconds;
   logic [1:0]  rsp_clock_mode;
   logic [2:0]  rsp_event_status;
   logic        csr_valid    = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data     = '0;

   int mismatch_count;
   int readings_outstanding;
   int idle_cycles   = 0;
   int stall_hold    = 0;
   int stall_roll;
   int quiet_items   = 0;
   int phase_items   = 0;
   int current_limit = int'(PRESCALE_RESET);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   settable_time_of_day_clock dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hours        (rsp_hours),
      .rsp_minutes      (rsp_minutes),
      .rsp_seconds      (rsp_seconds),
      .rsp_clock_mode   (rsp_clock_mode),
      .rsp_event_status (rsp_event_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   stod_reading_checker checker_inst (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key_code         (req_key_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hours            (rsp_hours),
      .rsp_minutes          (rsp_minutes),
      .rsp_seconds          (rsp_seconds),
      .rsp_clock_mode       (rsp_clock_mode),
      .rsp_event_status     (rsp_event_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .readings_outstanding (readings_outstanding)
   );

   // Response stalls: mostly short, a few long, and some stall-free stretches.
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 10) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(40, 150);
         end else if (stall_roll < 55) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
         end else if (stall_roll < 92) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(8, 30);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Idle cycles before the next request; none during a quiet stretch.
   function automatic int next_gap();
      int roll;
      if (quiet_items > 0) begin
         quiet_items--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet_items = $urandom_range(30, 100);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Mostly keys the clock reacts to, otherwise any byte.
   function automatic logic [7:0] random_key();
      if ($urandom_range(0, 99) < 65) return KNOWN_KEYS[$urandom_range(0, 8)];
      return 8'($urandom_range(0, 255));
   endfunction

   // One request transfer; valid stays high when the next request follows at once.
   task automatic send_item(input logic kind, input logic [7:0] key);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_key_code <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      phase_items++;
   endtask

   task automatic press(input logic [7:0] key);
      send_item(REQ_KEY, key);
   endtask

   task automatic tick();
      send_item(REQ_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Write the prescale limit once every reading has come back.
   task automatic write_limit(input logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      current_limit = int'(value);
   endtask

   initial begin
      logic [15:0] phase_limits [7];
      int          roll;
      int          count;
      phase_limits = '{16'd0, 16'd65535, 16'd2, PRESCALE_RESET, 16'd1,
                       16'($urandom_range(3, 12)), 16'($urandom_range(0, 65535))};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every mode and key class.
      write_limit(16'd1);
      tick();
      press(KEY_PAUSE);
      press(8'h00);
      press(8'hFF);
      press(KEY_IGNORE);
      press(KEY_ADJUST);
      press(KEY_HOUR);
      press(KEY_MINUTE);
      press(KEY_SECOND);
      press(KEY_GO);
      press(KEY_IGNORE);
      press(KEY_DONE);
      repeat (3) tick();
      press(KEY_ADJUST);
      press(KEY_IGNORE);
      press(KEY_PAUSE);
      tick();
      press(KEY_GO);
      tick();
      press(KEY_PAUSE);
      press(KEY_RESET);
      press(KEY_PAUSE);

      // Random sequences under each prescale limit.
      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // Set the time near midnight, then run a burst of ticks.
               press(KEY_PAUSE);
               press(KEY_DONE);
               press(KEY_PAUSE);
               press(KEY_RESET);
               press(KEY_ADJUST);
               repeat ($urandom_range(21, 24)) press(KEY_HOUR);
               repeat ($urandom_range(56, 60)) press(KEY_MINUTE);
               repeat ($urandom_range(52, 60)) press(KEY_SECOND);
               press(KEY_DONE);
               if (current_limit <= 8) begin
                  count = (current_limit + 1) * $urandom_range(1, 10) + $urandom_range(0, 2);
               end else begin
                  count = $urandom_range(5, 40);
               end
               repeat (count) tick();
               press(KEY_PAUSE);
            end else if (roll < 45) begin
               // Enter adjust from any mode, edit fields, then run a little.
               press(KEY_PAUSE);
               press(KEY_ADJUST);
               repeat ($urandom_range(0, 12)) begin
                  if ($urandom_range(0, 99) < 80) begin
                     press(KNOWN_KEYS[$urandom_range(4, 6)]);
                  end else begin
                     press(random_key());
                  end
               end
               press(KEY_DONE);
               repeat ($urandom_range(0, 20)) tick();
            end else if (roll < 75) begin
               // Burst of ticks with an occasional key.
               press(KEY_GO);
               repeat ($urandom_range(5, 40)) begin
                  if ($urandom_range(0, 99) < 85) tick();
                  else press(random_key());
               end
               if ($urandom_range(0, 1) == 1) press(KEY_PAUSE);
            end else begin
               // Unstructured mix of ticks and keys.
               repeat ($urandom_range(1, 10)) send_item(1'($urandom_range(0, 1)), random_key());
            end
         end
      end

      // Drain outstanding readings, then give the verdict.
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/stod_pkg.sv
rtl/core/stod_step.sv
rtl/core/settable_time_of_day_clock.sv
sim/stod_reading_checker.sv
sim/tb_settable_time_of_day_clock.sv
